// ===== sv/wrs_pkg.sv =====
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared constants, types and command/status structs for the water ripple
// stencil step block.
// ----------------------------------------------------------------------------
package wrs_pkg;

   // grid geometry (both sides powers of two, cell address is {col,row})
   localparam int GRID_W    = 256;
   localparam int GRID_H    = 256;
   localparam int COL_BITS  = $clog2(GRID_W);
   localparam int ROW_BITS  = $clog2(GRID_H);
   localparam int ADDR_BITS = COL_BITS + ROW_BITS;

   // value widths
   localparam int CELL_BITS  = 16;
   localparam int SUM_BITS   = CELL_BITS + 2;
   localparam int DAMP_BITS  = 17;
   localparam int SCALE_BITS = 15;
   localparam int PROD_BITS  = 2 * SUM_BITS;
   localparam int PIX_BITS   = 8;
   localparam int NUM_BITS   = SCALE_BITS + PIX_BITS;
   localparam int CNT_BITS   = $clog2(PIX_BITS + 1);
   localparam int Q16_SHIFT  = 16;

   localparam logic [DAMP_BITS-1:0]  DAMP_RESET  = DAMP_BITS'(65536);
   localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(500);
   localparam logic [PIX_BITS-1:0]   PIX_MAX     = PIX_BITS'(255);

   // configuration register indexes
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DAMPING = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE   = 1'b1;

   // item kinds
   localparam logic KIND_DROP = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DROP, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
      ST_SUM, ST_MUL, ST_SAT, ST_DIV
   } state_type;

   typedef enum logic [1:0] {NB_LEFT, NB_RIGHT, NB_UP, NB_DOWN} nb_sel_type;

   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_type;

   typedef struct packed {
      logic       clr_wr;
      logic       item_load;
      logic       drop_wr;
      nb_sel_type nb_sel;
      acc_op_type acc_op;
      logic       own_cap;
      logic       mul_en;
      logic       sat_en;
      logic       div_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic req_is_drop;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== sv/wrs_ram.sv =====
// ----------------------------------------------------------------------------
// wrs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wrs_ram #(
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [DATA_BITS-1:0] wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/wrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// wrs_ctrl
// Sequencer: clearing pass, drop write, neighbour reads, damping, pixel
// division and result hand-off.
// ----------------------------------------------------------------------------
module wrs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  wrs_pkg::status_type status,
   output wrs_pkg::cmd_type    cmd
);
   import wrs_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.nb_sel = NB_LEFT;
      cmd.acc_op = ACC_HOLD;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.item_load = 1'b1;
               state_in = status.req_is_drop ? ST_DROP : ST_RD0;
            end
         end
         ST_DROP: begin
            cmd.drop_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_RD0: begin
            cmd.nb_sel = NB_LEFT;
            state_in   = ST_RD1;
         end
         ST_RD1: begin
            cmd.nb_sel  = NB_RIGHT;
            cmd.acc_op  = ACC_LOAD;
            cmd.own_cap = 1'b1;
            state_in    = ST_RD2;
         end
         ST_RD2: begin
            cmd.nb_sel = NB_UP;
            cmd.acc_op = ACC_ADD;
            state_in   = ST_RD3;
         end
         ST_RD3: begin
            cmd.nb_sel = NB_DOWN;
            cmd.acc_op = ACC_ADD;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat_en = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_done) begin
               cmd.div_step = 1'b1;
            end else if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // result only loaded into a free output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free && status.div_done)
      else $error("result loaded over a pending one");

   // a drop write always follows the acceptance of its item
   a_drop_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.drop_wr |-> $past(cmd.item_load))
      else $error("drop write without accepted item");

   // no item taken during the clearing pass
   a_no_item_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_wr |-> !req_tready)
      else $error("item accepted while clearing");

endmodule

// ===== sv/wrs_datapath.sv =====
// ----------------------------------------------------------------------------
// wrs_datapath
// Height buffers, scan position, neighbour accumulator, damping multiplier,
// restoring pixel divider and result register.
// ----------------------------------------------------------------------------
module wrs_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  wrs_pkg::cmd_type                       cmd,
   output wrs_pkg::status_type                    status,
   // configuration writes
   input  logic                                   csr_we,
   input  logic [wrs_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [wrs_pkg::DAMP_BITS-1:0]          csr_wdata,
   // item fields
   input  logic                                   req_kind,
   input  logic [wrs_pkg::COL_BITS-1:0]           req_drop_x,
   input  logic [wrs_pkg::ROW_BITS-1:0]           req_drop_y,
   input  logic signed [wrs_pkg::CELL_BITS-1:0]   req_drop_value,
   // result
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [wrs_pkg::PIX_BITS-1:0]           rsp_pixel,
   output logic signed [wrs_pkg::CELL_BITS-1:0]   rsp_cell_value,
   output logic [wrs_pkg::COL_BITS-1:0]           rsp_cell_x,
   output logic [wrs_pkg::ROW_BITS-1:0]           rsp_cell_y,
   output logic                                   rsp_frame_last
);
   import wrs_pkg::*;

   localparam logic [COL_BITS-1:0]  COL_MAX = COL_BITS'(GRID_W - 1);
   localparam logic [ROW_BITS-1:0]  ROW_MAX = ROW_BITS'(GRID_H - 1);
   localparam logic [ADDR_BITS-1:0] ADDR_MAX = '1;
   localparam logic signed [PROD_BITS-1:0] Q16_ROUND = PROD_BITS'((1 << Q16_SHIFT) - 1);
   localparam logic signed [PROD_BITS-1:0] CELL_HI = PROD_BITS'((1 << (CELL_BITS - 1)) - 1);
   localparam logic signed [PROD_BITS-1:0] CELL_LO = -CELL_HI - PROD_BITS'(1);

   // configuration registers
   logic [DAMP_BITS-1:0]  damp_ff;
   logic [SCALE_BITS-1:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         damp_ff  <= DAMP_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DAMPING: damp_ff  <= csr_wdata;
            CSR_SCALE:   scale_ff <= csr_wdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // control state: clear address, scan position, buffer roles
   logic [ADDR_BITS-1:0] clr_addr_ff;
   logic [COL_BITS-1:0]  scan_col_ff;
   logic [ROW_BITS-1:0]  scan_row_ff;
   logic                 older_sel_ff;   // 0: buffer b older
   logic                 col_last, row_last;

   assign col_last = (scan_col_ff == COL_MAX);
   assign row_last = (scan_row_ff == ROW_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         scan_col_ff  <= '0;
         scan_row_ff  <= '0;
         older_sel_ff <= 1'b0;
      end else begin
         if (cmd.clr_wr) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (cmd.out_load) begin
            if (row_last) begin
               scan_row_ff <= '0;
               if (col_last) begin
                  scan_col_ff  <= '0;
                  older_sel_ff <= ~older_sel_ff;
               end else begin
                  scan_col_ff <= scan_col_ff + 1'b1;
               end
            end else begin
               scan_row_ff <= scan_row_ff + 1'b1;
            end
         end
      end
   end

   // latched item (drop coordinates always lie inside the grid)
   logic [ADDR_BITS-1:0]        drop_addr_ff;
   logic signed [CELL_BITS-1:0] drop_value_ff;

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         drop_addr_ff  <= {req_drop_x, req_drop_y};
         drop_value_ff <= req_drop_value;
      end
   end

   // wrapped neighbour address
   logic [COL_BITS-1:0]  xl, xr;
   logic [ROW_BITS-1:0]  yu, yd;
   logic [ADDR_BITS-1:0] nb_addr, own_addr;

   always_comb begin
      xl = (scan_col_ff == '0) ? COL_MAX : scan_col_ff - 1'b1;
      xr = col_last ? '0 : scan_col_ff + 1'b1;
      yu = (scan_row_ff == '0) ? ROW_MAX : scan_row_ff - 1'b1;
      yd = row_last ? '0 : scan_row_ff + 1'b1;
      own_addr = {scan_col_ff, scan_row_ff};
      case (cmd.nb_sel)
         NB_LEFT:  nb_addr = {xl, scan_row_ff};
         NB_RIGHT: nb_addr = {xr, scan_row_ff};
         NB_UP:    nb_addr = {scan_col_ff, yu};
         NB_DOWN:  nb_addr = {scan_col_ff, yd};
         default:  nb_addr = own_addr;
      endcase
   end

   // height buffers
   logic                        a_we, b_we;
   logic [ADDR_BITS-1:0]        waddr, a_raddr, b_raddr;
   logic [CELL_BITS-1:0]        wdata, a_rdata, b_rdata;
   logic signed [CELL_BITS-1:0] older_rd, newer_rd;
   logic signed [CELL_BITS-1:0] v_sat;

   always_comb begin
      a_we = cmd.clr_wr | (cmd.sat_en & ~older_sel_ff) | (cmd.drop_wr & older_sel_ff);
      b_we = cmd.clr_wr | (cmd.sat_en & older_sel_ff) | (cmd.drop_wr & ~older_sel_ff);
      if (cmd.clr_wr) begin
         waddr = clr_addr_ff;
         wdata = '0;
      end else if (cmd.sat_en) begin
         waddr = own_addr;
         wdata = v_sat;
      end else begin
         waddr = drop_addr_ff;
         wdata = drop_value_ff;
      end
      a_raddr  = older_sel_ff ? nb_addr : own_addr;
      b_raddr  = older_sel_ff ? own_addr : nb_addr;
      older_rd = older_sel_ff ? a_rdata : b_rdata;
      newer_rd = older_sel_ff ? b_rdata : a_rdata;
   end

   wrs_ram #(.ADDR_BITS(ADDR_BITS), .DATA_BITS(CELL_BITS)) u_buf_a (
      .clock(clock), .we(a_we), .waddr(waddr), .wdata(wdata),
      .raddr(a_raddr), .rdata(a_rdata)
   );

   wrs_ram #(.ADDR_BITS(ADDR_BITS), .DATA_BITS(CELL_BITS)) u_buf_b (
      .clock(clock), .we(b_we), .waddr(waddr), .wdata(wdata),
      .raddr(b_raddr), .rdata(b_rdata)
   );

   // neighbour sum and own value
   logic signed [SUM_BITS-1:0]  acc_ff;
   logic signed [CELL_BITS-1:0] own_ff;

   always_ff @(posedge clock) begin
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= SUM_BITS'(older_rd);
         ACC_ADD:  acc_ff <= acc_ff + SUM_BITS'(older_rd);
         default:  ;
      endcase
      if (cmd.own_cap) own_ff <= newer_rd;
   end

   // halve toward zero, subtract own value, apply damping
   logic signed [SUM_BITS-1:0]  half, diff;
   logic signed [PROD_BITS-1:0] prod_ff;

   always_comb begin
      half = (acc_ff + $signed(SUM_BITS'(acc_ff[SUM_BITS-1]))) >>> 1;
      diff = half - SUM_BITS'(own_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) prod_ff <= diff * $signed({1'b0, damp_ff});
   end

   // Q16 scale toward zero and saturate; pixel dividend
   logic signed [PROD_BITS-1:0] prod_q;
   logic [NUM_BITS-1:0]         num;
   logic [SCALE_BITS-1:0]       den;

   always_comb begin
      prod_q = (prod_ff + (prod_ff[PROD_BITS-1] ? Q16_ROUND : PROD_BITS'(0))) >>> Q16_SHIFT;
      if (prod_q > CELL_HI)      v_sat = CELL_HI[CELL_BITS-1:0];
      else if (prod_q < CELL_LO) v_sat = CELL_LO[CELL_BITS-1:0];
      else                       v_sat = prod_q[CELL_BITS-1:0];
      // v * 255 as (v << 8) - v; negative values give pixel 0
      num = v_sat[CELL_BITS-1] ? '0
          : (NUM_BITS'(v_sat) << PIX_BITS) - NUM_BITS'(v_sat);
      den = (scale_ff == '0) ? SCALE_BITS'(1) : scale_ff;
   end

   // restoring divider, one quotient bit per cycle
   logic signed [CELL_BITS-1:0] v_ff;
   logic [NUM_BITS-1:0]         rem_ff, den_sh_ff;
   logic [PIX_BITS-1:0]         q_ff;
   logic                        ovf_ff;
   logic [CNT_BITS-1:0]         cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.sat_en) begin
         cnt_ff <= CNT_BITS'(PIX_BITS);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sat_en) begin
         v_ff      <= v_sat;
         rem_ff    <= num;
         den_sh_ff <= NUM_BITS'({den, {(PIX_BITS - 1){1'b0}}});
         ovf_ff    <= (num >= {den, {PIX_BITS{1'b0}}});
         q_ff      <= '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= den_sh_ff) begin
            rem_ff <= rem_ff - den_sh_ff;
            q_ff   <= {q_ff[PIX_BITS-2:0], 1'b1};
         end else begin
            q_ff <= {q_ff[PIX_BITS-2:0], 1'b0};
         end
         den_sh_ff <= den_sh_ff >> 1;
      end
   end

   // result register
   logic                        rsp_valid_ff;
   logic [PIX_BITS-1:0]         pixel_ff;
   logic signed [CELL_BITS-1:0] cell_value_ff;
   logic [COL_BITS-1:0]         cell_x_ff;
   logic [ROW_BITS-1:0]         cell_y_ff;
   logic                        last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pixel_ff      <= ovf_ff ? PIX_MAX : q_ff;
         cell_value_ff <= v_ff;
         cell_x_ff     <= scan_col_ff;
         cell_y_ff     <= scan_row_ff;
         last_ff       <= col_last & row_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel      = pixel_ff;
   assign rsp_cell_value = cell_value_ff;
   assign rsp_cell_x     = cell_x_ff;
   assign rsp_cell_y     = cell_y_ff;
   assign rsp_frame_last = last_ff;

   // status to the sequencer
   assign status.clr_done    = (clr_addr_ff == ADDR_MAX);
   assign status.req_is_drop = (req_kind == KIND_DROP);
   assign status.div_done    = (cnt_ff == '0);
   assign status.out_free    = ~rsp_valid_ff | rsp_ready;

endmodule

// ===== sv/water_ripple_stencil_step.sv =====
// ----------------------------------------------------------------------------
// water_ripple_stencil_step
// Two-buffer water ripple height field on a 256 x 256 torus, one cell per
// advance item, with drop writes.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over both height buffers and
// takes no item until it ends. An advance item runs four neighbour reads
// through the older buffer's single read port, sum, damping multiply,
// saturation, and an 8-step restoring divider for the pixel, one quotient
// bit per cycle. The next item is accepted while a result still waits in
// the output register.
module water_ripple_stencil_step (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_we,
   input  logic [wrs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [wrs_pkg::DAMP_BITS-1:0]       csr_wdata,
   // items in
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,  // drop_x, drop_y, drop_value
   input  logic                                req_tuser,  // kind
   // results out
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [39:0]                         rsp_tdata,  // pixel, cell_value, cell_x, cell_y
   output logic                                rsp_tlast   // frame_last
);
   import wrs_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic [PIX_BITS-1:0]         pixel;
   logic signed [CELL_BITS-1:0] cell_value;
   logic [COL_BITS-1:0]         cell_x;
   logic [ROW_BITS-1:0]         cell_y;

   wrs_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .status(status), .cmd(cmd)
   );

   wrs_datapath u_dp (
      .clock(clock), .reset(reset),
      .cmd(cmd), .status(status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_kind(req_tuser),
      .req_drop_x(req_tdata[7:0]),
      .req_drop_y(req_tdata[15:8]),
      .req_drop_value(req_tdata[31:16]),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_pixel(pixel), .rsp_cell_value(cell_value),
      .rsp_cell_x(cell_x), .rsp_cell_y(cell_y),
      .rsp_frame_last(rsp_tlast)
   );

   assign rsp_tdata = {cell_y, cell_x, cell_value, pixel};

endmodule
